### rtl/core/krit_pkg.sv
// Shared types and constants for the keyed recent id table.
// Holds the field widths, operation and status codes, and the command and
// status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package krit_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 3;
    localparam int FILL_W   = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_FIND = 2'd1,
        MODE_DEL  = 2'd2
    } t_mode;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Kind of result word loaded into the output register
    typedef enum logic [2:0] {
        EMIT_FULL   = 3'd0,
        EMIT_MISS   = 3'd1,
        EMIT_OKZERO = 3'd2,
        EMIT_ADD    = 3'd3,
        EMIT_FIND   = 3'd4
    } t_emit;

    typedef struct packed {
        logic  load;    // capture input word, restart the slot scan
        logic  scan;    // step the slot scan
        logic  claim;   // take the lowest free slot for the key
        logic  del;     // free the matched slot
        logic  hclr;    // history counter to zero
        logic  hset1;   // history counter to one
        logic  shift;   // step the history shift
        logic  hrd;     // read history entry at the counter
        logic  hinc;    // advance history counter
        logic  put;     // write the new id, update fill
        logic  emit;    // load the output register
        t_emit kind;
    } t_cmd;

    typedef struct packed {
        logic              scan_last;
        logic              hit;
        logic              free;
        logic [MODE_W-1:0] mode;
        logic              fill_full;
        logic              fill_zero;
        logic              shift_done;
        logic              out_free;
        logic              find_last;
        logic              one_deep;
    } t_stat;

endpackage

### rtl/core/krit_dpath.sv
// Datapath of the keyed recent id table: slot valid flags, key, fill and
// history memories, scan and history counters, and the output register.
// Depends on krit_pkg; driven by krit_ctrl through krit_pkg::t_cmd.
`timescale 1ns / 1ps

module krit_dpath #(
    parameter int ENTRIES = 16,
    parameter int DEPTH   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  krit_pkg::t_cmd                     i_cmd,
    output krit_pkg::t_stat                    o_stat,
    input  logic [krit_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [krit_pkg::KEY_W-1:0]  i_key,
    input  logic [krit_pkg::ID_W-1:0]          i_request_id,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [krit_pkg::STATUS_W-1:0]      o_status,
    output logic [krit_pkg::ID_W-1:0]          o_stored_id,
    output logic [krit_pkg::POS_W-1:0]         o_position,
    output logic [krit_pkg::FILL_W-1:0]        o_fill,
    output logic                               o_last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int HN = ENTRIES * DEPTH;
    localparam int HW = (HN > 1) ? $clog2(HN) : 1;

    logic signed [krit_pkg::KEY_W-1:0] mem_key  [ENTRIES];
    logic [FW-1:0]                     mem_fill [ENTRIES];
    logic [krit_pkg::ID_W-1:0]         mem_hist [HN];

    logic [krit_pkg::MODE_W-1:0]       r_mode;
    logic signed [krit_pkg::KEY_W-1:0] r_key;
    logic [krit_pkg::ID_W-1:0]         r_id;
    logic [ENTRIES-1:0]                r_valid;
    logic [CW-1:0]                     r_scan_cnt;
    logic                              r_cmp_vld;
    logic [IW-1:0]                     r_cmp_idx;
    logic signed [krit_pkg::KEY_W-1:0] r_key_q;
    logic [FW-1:0]                     r_fill_q;
    logic                              r_vld_q;
    logic                              r_hit;
    logic [IW-1:0]                     r_slot;
    logic                              r_free;
    logic [IW-1:0]                     r_free_slot;
    logic [FW-1:0]                     r_fill;
    logic [FW-1:0]                     r_hcnt;
    logic                              r_hrd_vld;
    logic [FW-1:0]                     r_hrd_idx;
    logic [krit_pkg::ID_W-1:0]         r_hist_q;
    logic                              r_out_valid;
    logic [krit_pkg::STATUS_W-1:0]     r_status;
    logic [krit_pkg::ID_W-1:0]         r_stored_id;
    logic [krit_pkg::POS_W-1:0]        r_position;
    logic [krit_pkg::FILL_W-1:0]       r_out_fill;
    logic                              r_last;

    logic                      scan_issue;
    logic [IW-1:0]             scan_idx;
    logic                      match;
    logic                      free_seen;
    logic                      fill_full;
    logic [FW-1:0]             fill_put;
    logic                      shift_issue;
    logic [HW-1:0]             base;
    logic [HW-1:0]             hist_raddr;
    logic [HW-1:0]             hist_waddr;
    logic [krit_pkg::ID_W-1:0] hist_wdata;
    logic                      hist_we;
    logic                      hist_re;
    logic                      find_last;

    assign scan_issue  = i_cmd.scan && (r_scan_cnt < CW'(ENTRIES));
    assign scan_idx    = r_scan_cnt[IW-1:0];
    assign match       = r_cmp_vld && r_vld_q && (r_key_q == r_key);
    assign free_seen   = r_cmp_vld && !r_vld_q;
    assign fill_full   = (r_fill == FW'(DEPTH));
    assign fill_put    = fill_full ? r_fill : r_fill + FW'(1);
    assign shift_issue = i_cmd.shift && (r_hcnt < FW'(DEPTH));
    assign base        = HW'(r_slot * DEPTH);
    assign hist_raddr  = base + HW'(r_hcnt);
    assign hist_re     = i_cmd.hrd || shift_issue;
    assign hist_we     = i_cmd.put || r_hrd_vld;
    assign find_last   = ((FW + 1)'(r_hcnt) + (FW + 1)'(1)) == (FW + 1)'(r_fill);

    always_comb begin
        if (r_hrd_vld) begin
            hist_waddr = base + HW'(r_hrd_idx) - HW'(1);
            hist_wdata = r_hist_q;
        end else begin
            hist_waddr = base + (fill_full ? HW'(DEPTH - 1) : HW'(r_fill));
            hist_wdata = r_id;
        end
    end

    always_comb begin
        o_stat.scan_last  = r_cmp_vld && (r_cmp_idx == IW'(ENTRIES - 1));
        o_stat.hit        = r_hit;
        o_stat.free       = r_free;
        o_stat.mode       = r_mode;
        o_stat.fill_full  = fill_full;
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.shift_done = r_hrd_vld && (r_hrd_idx == FW'(DEPTH - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.find_last  = find_last;
        o_stat.one_deep   = (DEPTH == 1);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_scan_cnt  <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_hcnt      <= '0;
            r_hrd_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan_cnt <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
            end else begin
                if (scan_issue) begin
                    r_scan_cnt <= r_scan_cnt + CW'(1);
                end
                if (match) begin
                    r_hit <= 1'b1;
                end
                if (free_seen) begin
                    r_free <= 1'b1;
                end
            end
            r_cmp_vld <= scan_issue;
            if (i_cmd.claim) begin
                r_valid[r_free_slot] <= 1'b1;
            end
            if (i_cmd.del) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (i_cmd.hclr) begin
                r_hcnt <= '0;
            end else if (i_cmd.hset1) begin
                r_hcnt <= FW'(1);
            end else if (shift_issue || i_cmd.hinc) begin
                r_hcnt <= r_hcnt + FW'(1);
            end
            r_hrd_vld <= shift_issue;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_id   <= i_request_id;
        end
        if (scan_issue) begin
            r_cmp_idx <= scan_idx;
            r_vld_q   <= r_valid[scan_idx];
        end
        if (match && !r_hit) begin
            r_slot <= r_cmp_idx;
            r_fill <= r_fill_q;
        end
        if (free_seen && !r_free) begin
            r_free_slot <= r_cmp_idx;
        end
        if (i_cmd.claim) begin
            r_slot <= r_free_slot;
            r_fill <= '0;
        end
        if (i_cmd.put) begin
            r_fill <= fill_put;
        end
        if (shift_issue) begin
            r_hrd_idx <= r_hcnt;
        end
    end

    // Key and fill memories: one read port for the scan, one write port
    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_key_q  <= mem_key[scan_idx];
            r_fill_q <= mem_fill[scan_idx];
        end
        if (i_cmd.claim) begin
            mem_key[r_free_slot] <= r_key;
        end
        if (i_cmd.put) begin
            mem_fill[r_slot] <= fill_put;
        end
    end

    // History memory
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            mem_hist[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            r_hist_q <= mem_hist[hist_raddr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_stored_id <= '0;
            r_position  <= '0;
            r_out_fill  <= '0;
            r_last      <= 1'b1;
            case (i_cmd.kind)
                krit_pkg::EMIT_FULL: begin
                    r_status <= krit_pkg::ST_FULL;
                end
                krit_pkg::EMIT_MISS: begin
                    r_status <= krit_pkg::ST_NOT_FOUND;
                end
                krit_pkg::EMIT_ADD: begin
                    r_status   <= krit_pkg::ST_OK;
                    r_out_fill <= krit_pkg::FILL_W'(r_fill);
                end
                krit_pkg::EMIT_FIND: begin
                    r_status    <= krit_pkg::ST_OK;
                    r_stored_id <= r_hist_q;
                    r_position  <= krit_pkg::POS_W'(r_hcnt);
                    r_out_fill  <= krit_pkg::FILL_W'(r_fill);
                    r_last      <= find_last;
                end
                default: begin
                    r_status <= krit_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_stored_id = r_stored_id;
    assign o_position  = r_position;
    assign o_fill      = r_out_fill;
    assign o_last      = r_last;

endmodule

### rtl/core/krit_ctrl.sv
// Controller of the keyed recent id table: sequences scan, add, shift,
// find and delete steps. Depends on krit_pkg; drives krit_dpath.
`timescale 1ns / 1ps

module krit_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  krit_pkg::t_stat i_stat,
    output krit_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_ADD    = 9'b000001000,
        S_SHIFT  = 9'b000010000,
        S_PUT    = 9'b000100000,
        S_RESP   = 9'b001000000,
        S_FRD    = 9'b010000000,
        S_FEMIT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.kind = krit_pkg::EMIT_OKZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_stat.mode)
                    krit_pkg::MODE_ADD: begin
                        if (i_stat.hit) begin
                            n_state = S_ADD;
                        end else if (i_stat.free) begin
                            o_cmd.claim = 1'b1;
                            n_state     = S_ADD;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = krit_pkg::EMIT_FULL;
                            n_state    = S_IDLE;
                        end
                    end
                    krit_pkg::MODE_FIND: begin
                        if (i_stat.hit && !i_stat.fill_zero) begin
                            o_cmd.hclr = 1'b1;
                            n_state    = S_FRD;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = i_stat.hit ? krit_pkg::EMIT_OKZERO
                                                    : krit_pkg::EMIT_MISS;
                            n_state    = S_IDLE;
                        end
                    end
                    krit_pkg::MODE_DEL: begin
                        if (i_stat.out_free) begin
                            o_cmd.del  = i_stat.hit;
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = i_stat.hit ? krit_pkg::EMIT_OKZERO
                                                    : krit_pkg::EMIT_MISS;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ADD: begin
                if (i_stat.fill_full && !i_stat.one_deep) begin
                    o_cmd.hset1 = 1'b1;
                    n_state     = S_SHIFT;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = krit_pkg::EMIT_ADD;
                    n_state    = S_IDLE;
                end
            end
            S_FRD: begin
                o_cmd.hrd = 1'b1;
                n_state   = S_FEMIT;
            end
            S_FEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = krit_pkg::EMIT_FIND;
                    if (i_stat.find_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.hinc = 1'b1;
                        n_state    = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/keyed_recent_id_table.sv
// Top level of the keyed recent id table: stream ports, controller and
// datapath. Depends on krit_pkg, krit_ctrl and krit_dpath.
`timescale 1ns / 1ps

// A table of ENTRIES slots, each holding a 32-bit key and the DEPTH most
// recent 16-bit request ids added under it. Each input word carries an
// operation in tuser: add appends the id to the key's slot (claiming the
// lowest free slot and starting an empty history if the key is new, or
// dropping the oldest id once the history is full), find returns the held
// ids oldest first with tlast on the newest, and delete frees the slot.
// A key matches the lowest valid slot with equal bits. Add with no free
// slot returns status table full and stores nothing; find or delete of an
// absent key returns status not found; operation code 3 is consumed with
// no result. Add, delete, a miss or an empty find return exactly one word with tlast set.
// Order of work, with the output side ready: each word first scans the key
// memory one slot per cycle; an add into a full history then moves one id
// per cycle through the history memory before the new id is written, and a
// find hit does one history read and one output load per id returned.
// Results go through a one-word output register, so a new input word is
// taken while the final result still waits for the downstream side.
// No clearing pass is needed after reset: slot valid flags reset at once.
module keyed_recent_id_table #(
    parameter int ENTRIES = 16,
    parameter int DEPTH   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [31:0] key, [47:32] request_id
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] stored_id, [18:16] position,
                                          // [22:19] fill, [23] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast    // last
);

    krit_pkg::t_cmd  cmd;
    krit_pkg::t_stat stat;

    logic [krit_pkg::MODE_W-1:0]       in_mode;
    logic signed [krit_pkg::KEY_W-1:0] in_key;
    logic [krit_pkg::ID_W-1:0]         in_request_id;
    logic [krit_pkg::STATUS_W-1:0]     out_status;
    logic [krit_pkg::ID_W-1:0]         out_stored_id;
    logic [krit_pkg::POS_W-1:0]        out_position;
    logic [krit_pkg::FILL_W-1:0]       out_fill;

    // Unpack the input word
    assign in_mode       = i_s_axis_tuser;
    assign in_key        = signed'(i_s_axis_tdata[31:0]);
    assign in_request_id = i_s_axis_tdata[47:32];

    krit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    krit_dpath #(
        .ENTRIES (ENTRIES),
        .DEPTH   (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (in_mode),
        .i_key        (in_key),
        .i_request_id (in_request_id),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_status     (out_status),
        .o_stored_id  (out_stored_id),
        .o_position   (out_position),
        .o_fill       (out_fill),
        .o_last       (o_m_axis_tlast)
    );

    // Pack the result word, pad to a whole byte
    assign o_m_axis_tdata = {1'b0, out_fill, out_position, out_stored_id};
    assign o_m_axis_tuser = out_status;

    // A result is loaded only when the output register can take it
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while output register is occupied");

    // An accepted word always starts a slot scan on the next cycle
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> cmd.scan)
        else $error("accepted word did not start a scan");

    // A slot is claimed only for a new key with a free slot found
    a_claim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.claim |-> (!stat.hit && stat.free))
        else $error("slot claimed for a present key or a full table");

    // History ids are returned only for a key that was found
    a_find_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && (cmd.kind == krit_pkg::EMIT_FIND)) |-> stat.hit)
        else $error("history id returned for an absent key");

endmodule

### tb/sv/keyed_recent_id_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for keyed_recent_id_table: add, find and delete words
// against an in-bench table model, with random idling on both streams.
// Depends on krit_pkg and the keyed_recent_id_table RTL.

module keyed_recent_id_table_test;

    localparam int ENTRIES      = 16;
    localparam int DEPTH        = 8;
    localparam int RANDOM_WORDS = 90;    // non-ignored words in the random part
    localparam int POOL_KEYS    = 24;    // more keys than slots, so the table fills
    localparam int HOLD_AFTER   = 40;    // results seen before the long receiver hold
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake on either side

    localparam logic [krit_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One queued input word, or a marker that pauses the sender until the
    // table has returned every outstanding result.
    typedef struct packed {
        logic                        drain;
        logic [krit_pkg::MODE_W-1:0] mode;
        logic [krit_pkg::KEY_W-1:0]  key;
        logic [krit_pkg::ID_W-1:0]   id;
    } t_op_word;

    // Field order matches {tuser, tdata, tlast} on the result stream.
    typedef struct packed {
        logic [krit_pkg::STATUS_W-1:0] status;
        logic                          pad;
        logic [krit_pkg::FILL_W-1:0]   fill;
        logic [krit_pkg::POS_W-1:0]    position;
        logic [krit_pkg::ID_W-1:0]     stored_id;
        logic                          last;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // [31:0] key, [47:32] request_id
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // [15:0] stored_id, [18:16] position,
                                        // [22:19] fill, [23] zero
    logic [1:0]  o_m_axis_tuser;        // [1:0] status
    logic        o_m_axis_tlast;

    keyed_recent_id_table #(
        .ENTRIES(ENTRIES),
        .DEPTH  (DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Table model: slot flags, keys, counts and id histories.
    logic                       slot_used [ENTRIES];
    logic [krit_pkg::KEY_W-1:0] slot_key  [ENTRIES];
    int                         slot_fill [ENTRIES];
    logic [krit_pkg::ID_W-1:0]  id_history[ENTRIES][DEPTH];

    t_op_word                   pending_words[$];
    t_table_result              expected_results[$];
    logic [krit_pkg::KEY_W-1:0] key_pool[POOL_KEYS];

    int words_queued = 0;
    int words_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int cnt_add = 0, cnt_shift = 0, cnt_full = 0, cnt_hit = 0;
    int cnt_miss = 0, cnt_del = 0, cnt_ignored = 0;

    task automatic push_result(input logic [krit_pkg::STATUS_W-1:0] status,
                               input logic [krit_pkg::ID_W-1:0] stored_id,
                               input logic [krit_pkg::POS_W-1:0] position,
                               input logic [krit_pkg::FILL_W-1:0] fill,
                               input logic last);
        t_table_result r;
        r.status    = status;
        r.pad       = 1'b0;
        r.fill      = fill;
        r.position  = position;
        r.stored_id = stored_id;
        r.last      = last;
        expected_results.push_back(r);
    endtask

    // Apply one accepted word to the model and queue the words it returns.
    task automatic table_apply(input t_op_word w);
        int s;
        int n;
        s = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (slot_used[i] && slot_key[i] == w.key) s = i;
        if (w.mode == krit_pkg::MODE_ADD) begin
            if (s < 0) begin
                // claim the lowest free slot and start an empty history
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!slot_used[i]) s = i;
                if (s >= 0) begin
                    slot_used[s] = 1'b1;
                    slot_key[s]  = w.key;
                    slot_fill[s] = 0;
                end
            end
            if (s < 0) begin
                push_result(krit_pkg::ST_FULL, '0, '0, '0, 1'b1);
                cnt_full++;
            end else begin
                n = slot_fill[s];
                if (n < DEPTH) begin
                    id_history[s][n] = w.id;
                    slot_fill[s] = n + 1;
                end else begin
                    // history full: drop the oldest id
                    for (int i = 1; i < DEPTH; i++)
                        id_history[s][i-1] = id_history[s][i];
                    id_history[s][DEPTH-1] = w.id;
                    cnt_shift++;
                end
                push_result(krit_pkg::ST_OK, '0, '0,
                            krit_pkg::FILL_W'(slot_fill[s]), 1'b1);
                cnt_add++;
            end
        end else if (w.mode == krit_pkg::MODE_FIND) begin
            if (s < 0) begin
                push_result(krit_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
                cnt_miss++;
            end else begin
                n = slot_fill[s];
                if (n == 0)
                    push_result(krit_pkg::ST_OK, '0, '0, '0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_result(krit_pkg::ST_OK, id_history[s][i],
                                krit_pkg::POS_W'(i), krit_pkg::FILL_W'(n),
                                (i == n - 1));
                cnt_hit++;
            end
        end else if (w.mode == krit_pkg::MODE_DEL) begin
            if (s < 0) begin
                push_result(krit_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
                cnt_miss++;
            end else begin
                slot_used[s] = 1'b0;
                push_result(krit_pkg::ST_OK, '0, '0, '0, 1'b1);
                cnt_del++;
            end
        end else begin
            cnt_ignored++;
        end
    endtask

    task automatic queue_word(input logic [krit_pkg::MODE_W-1:0] mode,
                              input logic [krit_pkg::KEY_W-1:0] key,
                              input logic [krit_pkg::ID_W-1:0] id);
        t_op_word w;
        w.drain = 1'b0;
        w.mode  = mode;
        w.key   = key;
        w.id    = id;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Sender: hold a word until taken, then take a random gap or go on.
    t_op_word cur_word = '0;
    logic     tx_busy = 1'b0;
    int       tx_gap = 0;
    int       tx_run = 0;
    int       tx_roll;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            tx_busy = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                table_apply(cur_word);
                words_taken++;
                tx_busy = 1'b0;
                if (tx_run > 0) begin
                    tx_run--;
                    tx_gap = 0;
                end else begin
                    tx_roll = $urandom_range(0, 99);
                    if (tx_roll < 8) begin
                        tx_run = $urandom_range(15, 40);
                        tx_gap = 0;
                    end else if (tx_roll < 50) begin
                        tx_gap = 0;
                    end else if (tx_roll < 88) begin
                        tx_gap = $urandom_range(1, 3);
                    end else begin
                        tx_gap = $urandom_range(10, 40);
                    end
                end
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_words.size() > 0 && pending_words[0].drain) begin
                    // pause until every outstanding result is back
                    if (expected_results.size() == 0)
                        void'(pending_words.pop_front());
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    tx_busy = 1'b1;
                end
            end
            i_s_axis_tvalid <= tx_busy;
            i_s_axis_tdata  <= {cur_word.id, cur_word.key};
            i_s_axis_tuser  <= cur_word.mode;
        end
    end

    // Receiver: check each taken result against the oldest expectation and
    // throttle tready, including one long hold so the table backs up.
    t_table_result got_result, want_result;
    logic rx_ready = 1'b0;
    logic long_hold_done = 1'b0;
    int   rx_stall = 0;
    int   rx_run = 0;
    int   rx_roll;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_result = {o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast};
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: st %0d id %h pos %0d fill %0d last %0d",
                             $time, got_result.status, got_result.stored_id,
                             got_result.position, got_result.fill, got_result.last);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result !== want_result) begin
                        errors++;
                        $display("%0t: expected st %0d id %h pos %0d fill %0d last %0d pad %0d",
                                 $time, want_result.status, want_result.stored_id,
                                 want_result.position, want_result.fill, want_result.last,
                                 want_result.pad);
                        $display("%0t: actual   st %0d id %h pos %0d fill %0d last %0d pad %0d",
                                 $time, got_result.status, got_result.stored_id,
                                 got_result.position, got_result.fill, got_result.last,
                                 got_result.pad);
                    end
                end
            end
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                rx_stall = LONG_HOLD;
                rx_run = 0;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                rx_ready = 1'b0;
            end else if (rx_run > 0) begin
                rx_run--;
                rx_ready = 1'b1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                rx_ready = 1'b1;
                if (rx_roll < 10) begin
                    rx_run = $urandom_range(20, 60);
                end else if (rx_roll >= 55 && rx_roll < 90) begin
                    rx_ready = 1'b0;
                    rx_stall = $urandom_range(0, 2);
                end else if (rx_roll >= 90) begin
                    rx_ready = 1'b0;
                    rx_stall = $urandom_range(9, 39);
                end
            end
            i_m_axis_tready <= rx_ready;
        end
    end

    // Watchdog: end the run if neither stream moves for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, expected_results.size());
            $display("[keyed_recent_id_table] ERROR");
            $finish;
        end
    end

    initial begin
        t_op_word marker;
        logic [krit_pkg::KEY_W-1:0] k;
        int random_words;
        int episode;
        int pick;
        int n;
        int roll;
        logic mid_drain_done;

        for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_fill[i] = 0;
        end
        marker = '0;
        marker.drain = 1'b1;

        // Pool: the directed keys first, then the re-added key, then random.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;
        for (int i = 4; i < ENTRIES; i++)
            key_pool[i] = 32'hA5A5_0000 + i;
        key_pool[ENTRIES] = 32'h5A5A_5A5A;
        for (int i = ENTRIES + 1; i < POOL_KEYS; i++)
            key_pool[i] = $urandom;

        // Directed: misses on an empty table, the unused code, then fill
        // every slot with the key extremes and walk the full-table cases.
        queue_word(krit_pkg::MODE_FIND, 32'h0000_0000, 16'h0000);
        queue_word(krit_pkg::MODE_DEL, 32'h8000_0000, 16'hFFFF);
        queue_word(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        for (int i = 0; i < ENTRIES; i++)
            queue_word(krit_pkg::MODE_ADD, key_pool[i],
                       (i == 0) ? 16'hFFFF : 16'(i * 16'h1111));
        queue_word(krit_pkg::MODE_ADD, key_pool[ENTRIES], 16'h7777);  // no free slot
        queue_word(krit_pkg::MODE_ADD, key_pool[0], 16'h1234);        // known key appends
        queue_word(krit_pkg::MODE_FIND, key_pool[0], 16'h0000);       // two ids back
        queue_word(krit_pkg::MODE_DEL, key_pool[1], 16'h0000);
        queue_word(krit_pkg::MODE_FIND, key_pool[1], 16'h0000);       // deleted key misses
        queue_word(krit_pkg::MODE_ADD, key_pool[ENTRIES], 16'hBEEF);  // reclaims slot 1
        queue_word(krit_pkg::MODE_FIND, key_pool[ENTRIES], 16'h0000);
        pending_words.push_back(marker);

        // Random: episodes of deletes, history bursts, mixed traffic on the
        // key pool, and a little noise with arbitrary keys and codes.
        random_words = 0;
        episode = 0;
        mid_drain_done = 1'b0;
        while (random_words < RANDOM_WORDS) begin
            if (episode == 0)
                pick = 90;
            else if (episode == 1)
                pick = 0;
            else
                pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // burst of adds to one key, at times long enough to wrap the history
                k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                n = (episode == 1) ? DEPTH + 3 : $urandom_range(1, DEPTH + 3);
                for (int i = 0; i < n; i++)
                    queue_word(krit_pkg::MODE_ADD, k, 16'($urandom));
                queue_word(krit_pkg::MODE_FIND, k, 16'($urandom));
                random_words += n + 1;
            end else if (pick < 80) begin
                n = $urandom_range(4, 10);
                for (int i = 0; i < n; i++) begin
                    roll = $urandom_range(0, 99);
                    k = ($urandom_range(0, 9) == 0) ? krit_pkg::KEY_W'($urandom)
                                                    : key_pool[$urandom_range(0, POOL_KEYS - 1)];
                    if (roll < 45)
                        queue_word(krit_pkg::MODE_ADD, k, 16'($urandom));
                    else if (roll < 75)
                        queue_word(krit_pkg::MODE_FIND, k, 16'($urandom));
                    else if (roll < 95)
                        queue_word(krit_pkg::MODE_DEL, k, 16'($urandom));
                    else
                        queue_word(MODE_UNUSED, k, 16'($urandom));
                    if (roll < 95)
                        random_words++;
                end
            end else if (pick < 90) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    roll = $urandom_range(0, 3);
                    queue_word(krit_pkg::MODE_W'(roll), krit_pkg::KEY_W'($urandom),
                               16'($urandom));
                    if (roll != MODE_UNUSED)
                        random_words++;
                end
            end else begin
                // free a run of pool slots
                n = $urandom_range(3, 8);
                for (int i = 0; i < n; i++)
                    queue_word(krit_pkg::MODE_DEL,
                               key_pool[$urandom_range(0, POOL_KEYS - 1)], 16'($urandom));
                random_words += n;
            end
            if (!mid_drain_done && random_words >= RANDOM_WORDS / 2) begin
                mid_drain_done = 1'b1;
                pending_words.push_back(marker);
            end
            episode++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_queued)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words: %0d adds (%0d past a full history), %0d table full,",
                 words_taken, cnt_add, cnt_shift, cnt_full);
        $display("%0d find hits, %0d misses, %0d deletes, %0d ignored; %0d results checked",
                 cnt_hit, cnt_miss, cnt_del, cnt_ignored, results_seen);
        if (errors == 0)
            $display("[keyed_recent_id_table] OK");
        else
            $display("[keyed_recent_id_table] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/krit_pkg.sv
rtl/core/krit_dpath.sv
rtl/core/krit_ctrl.sv
rtl/core/keyed_recent_id_table.sv
tb/sv/keyed_recent_id_table_test.sv
